// ----- hw/rtl/lcgmx_pkg.sv -----
// Shared types, constants and the microcode program for the seed mixer.
`default_nettype none
package lcgmx_pkg;

	// drand48 generator constants
	localparam logic [47:0] LCG_MUL    = 48'h0005_DEEC_E66D;
	localparam logic [47:0] LCG_INC    = 48'h0000_0000_000B;
	localparam int          HALF_W     = 24;
	localparam logic [23:0] LCG_MUL_LO = LCG_MUL[23:0];
	localparam logic [23:0] LCG_MUL_HI = LCG_MUL[47:24];

	localparam int          MAX_ROUNDS = 4;
	localparam int          RND_W      = 3;

	// acceptance window for the candidate popcount
	localparam logic [4:0]  ONES_MIN   = 5'd5;
	localparam logic [4:0]  ONES_MAX   = 5'd11;

	typedef struct packed {
		logic signed [63:0] timer_sample;
		logic [31:0]        tick_count;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic [15:0]        seed;
		logic signed [63:0] mixed_value;
	} out_item_t;

	typedef enum logic [1:0] {
		MIX_HOLD,
		MIX_PRE,
		MIX_ADD_TIMER,
		MIX_STIR
	} mix_op_t;

	typedef enum logic [1:0] {
		MUL_L0_CLO,
		MUL_L0_CHI,
		MUL_L1_CLO
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_HI,
		ACC_FINISH
	} acc_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_JUMP,
		SEQ_WAIT_IN,
		SEQ_EMIT
	} seq_op_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_MIXIN  = 3'd1;
	localparam step_t STEP_MULHI  = 3'd2;
	localparam step_t STEP_LCGWR  = 3'd3;
	localparam step_t STEP_STIR   = 3'd4;
	localparam step_t STEP_EMIT   = 3'd5;
	localparam step_t STEP_RLOOP0 = 3'd6;
	localparam step_t STEP_RLOOP1 = 3'd7;

	typedef struct packed {
		mix_op_t  mix_op;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     rnd_inc;
		seq_op_t  seq_op;
		step_t    target;
	} uword_t;

	// sequencer -> datapath
	typedef struct packed {
		mix_op_t  mix_op;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     rnd_inc;
		logic     take_in;
		logic     emit;
	} dp_ctl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic loop_req;
		logic out_busy;
	} dp_sts_t;

	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		w = '{MIX_HOLD, MUL_L0_CLO, ACC_HOLD, 1'b0, SEQ_NEXT, STEP_IDLE};
		case (pc)
			STEP_IDLE:   w = '{MIX_PRE, MUL_L0_CLO, ACC_HOLD, 1'b0, SEQ_WAIT_IN, STEP_IDLE};
			STEP_MIXIN:  w = '{MIX_ADD_TIMER, MUL_L0_CHI, ACC_LOAD, 1'b0, SEQ_NEXT, STEP_IDLE};
			STEP_MULHI:  w = '{MIX_HOLD, MUL_L1_CLO, ACC_ADD_HI, 1'b0, SEQ_NEXT, STEP_IDLE};
			STEP_LCGWR:  w = '{MIX_HOLD, MUL_L0_CLO, ACC_FINISH, 1'b0, SEQ_NEXT, STEP_IDLE};
			STEP_STIR:   w = '{MIX_STIR, MUL_L0_CLO, ACC_HOLD, 1'b1, SEQ_NEXT, STEP_IDLE};
			STEP_EMIT:   w = '{MIX_HOLD, MUL_L0_CLO, ACC_HOLD, 1'b0, SEQ_EMIT, STEP_RLOOP0};
			STEP_RLOOP0: w = '{MIX_HOLD, MUL_L0_CLO, ACC_HOLD, 1'b0, SEQ_JUMP, STEP_RLOOP1};
			STEP_RLOOP1: w = '{MIX_HOLD, MUL_L0_CHI, ACC_LOAD, 1'b0, SEQ_JUMP, STEP_MULHI};
			default:     w = '{MIX_HOLD, MUL_L0_CLO, ACC_HOLD, 1'b0, SEQ_JUMP, STEP_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [4:0] ones16(input logic [15:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 16; i++) begin
			n = n + 5'(v[i]);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lcg_mixed_seed_generator.sv -----
// Each item runs one LCG round; each repeated round (mix equal to the previous
// one) runs another, at most 4 rounds. No new input is taken until the result
// is emitted. The shared 24x24 multiplier takes three passes per LCG update and
// the microcode runs one step per cycle, except while waiting for input or out_ready.
// Reset: arst_n clears the LCG value, mix state and round counter to zero and
// empties the result register.
`default_nettype none
module lcg_mixed_seed_generator (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  lcgmx_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output lcgmx_pkg::out_item_t out_data
);
	import lcgmx_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	lcgmx_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	lcgmx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/lcgmx_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none
module lcgmx_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  lcgmx_pkg::dp_sts_t sts,
	output lcgmx_pkg::dp_ctl_t ctl
);
	import lcgmx_pkg::*;

	step_t  pc_q;
	step_t  pc_d;
	uword_t w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		w           = ucode(pc_q);
		in_ready    = (w.seq_op == SEQ_WAIT_IN);
		ctl.mix_op  = w.mix_op;
		ctl.mul_sel = w.mul_sel;
		ctl.acc_op  = w.acc_op;
		ctl.rnd_inc = w.rnd_inc;
		ctl.take_in = (w.seq_op == SEQ_WAIT_IN) && in_valid;
		ctl.emit    = (w.seq_op == SEQ_EMIT) && !sts.loop_req && !sts.out_busy;
		case (w.seq_op)
			SEQ_NEXT:    pc_d = pc_q + 3'd1;
			SEQ_JUMP:    pc_d = w.target;
			SEQ_WAIT_IN: pc_d = in_valid ? pc_q + 3'd1 : pc_q;
			SEQ_EMIT: begin
				// mix repeated the previous one and rounds remain: run another LCG round
				if (sts.loop_req) begin
					pc_d = w.target;
				end else if (sts.out_busy) begin
					pc_d = pc_q;
				end else begin
					pc_d = STEP_IDLE;
				end
			end
			default:     pc_d = STEP_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lcgmx_dp.sv -----
// Datapath: mix register, shared 24x24 multiplier, LCG accumulator, result register.
`default_nettype none
module lcgmx_dp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lcgmx_pkg::dp_ctl_t  ctl,
	output lcgmx_pkg::dp_sts_t  sts,
	input  lcgmx_pkg::in_item_t in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output lcgmx_pkg::out_item_t out_data
);
	import lcgmx_pkg::*;

	logic [63:0]      timer_q;
	logic [15:0]      tick_q;
	logic [63:0]      mix_q;
	logic [63:0]      state_q;
	logic [47:0]      lcg_q;
	logic [47:0]      prod_q;
	logic [47:0]      acc_q;
	logic [RND_W-1:0] rnd_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [23:0] mul_a;
	logic [23:0] mul_b;
	logic [15:0] seed;
	logic [4:0]  ones;

	always_comb begin
		case (ctl.mul_sel)
			MUL_L0_CLO: begin
				mul_a = lcg_q[HALF_W-1:0];
				mul_b = LCG_MUL_LO;
			end
			MUL_L0_CHI: begin
				mul_a = lcg_q[HALF_W-1:0];
				mul_b = LCG_MUL_HI;
			end
			MUL_L1_CLO: begin
				mul_a = lcg_q[47:HALF_W];
				mul_b = LCG_MUL_LO;
			end
			default: begin
				mul_a = lcg_q[HALF_W-1:0];
				mul_b = LCG_MUL_LO;
			end
		endcase
		seed         = mix_q[15:0] + tick_q;
		ones         = ones16(seed);
		sts.loop_req = (mix_q == state_q) && (rnd_q < RND_W'(MAX_ROUNDS));
		sts.out_busy = out_valid_q && !out_ready;
	end

	// scratch registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (ctl.take_in) begin
			timer_q <= in_data.timer_sample;
			tick_q  <= in_data.tick_count[15:0];
		end
		case (ctl.mix_op)
			MIX_PRE:       mix_q <= {state_q[56:0], 7'b0} + {state_q[62:0], 1'b0};
			MIX_ADD_TIMER: mix_q <= mix_q + state_q + timer_q;
			MIX_STIR:      mix_q <= {16'b0, lcg_q} + {mix_q[62:0], 1'b0} + mix_q;
			default:       mix_q <= mix_q;
		endcase
		case (ctl.acc_op)
			ACC_LOAD:   acc_q <= prod_q;
			ACC_ADD_HI: acc_q <= {acc_q[47:HALF_W] + prod_q[HALF_W-1:0], acc_q[HALF_W-1:0]};
			default:    acc_q <= acc_q;
		endcase
		if (ctl.emit) begin
			out_q.mixed_value <= mix_q;
			out_q.seed        <= seed;
			out_q.accepted    <= seed[0] && (|seed[7:4]) && (|seed[11:8]) && seed[15]
				&& (ones >= ONES_MIN) && (ones <= ONES_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			lcg_q       <= '0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.acc_op == ACC_FINISH) begin
				lcg_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}} + LCG_INC;
			end
			if (ctl.take_in) begin
				rnd_q <= '0;
			end else if (ctl.rnd_inc) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (ctl.emit) begin
				state_q <= mix_q;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lcgmx_chk.sv -----
// Port-level checker for the seed mixer, bound to the top level.
`default_nettype none
module lcgmx_chk (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  out_valid,
	input wire                  out_ready,
	input lcgmx_pkg::out_item_t out_data
);
	import lcgmx_pkg::*;

	// one item at a time: busy right after an input transfer
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an input transfer");

	a_accept_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted |-> out_data.seed[0] && out_data.seed[15]
			&& (out_data.seed[7:4] != 4'd0) && (out_data.seed[11:8] != 4'd0))
		else $error("accepted seed breaks a bit rule");

	a_accept_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted |-> ($countones(out_data.seed) >= 5)
			&& ($countones(out_data.seed) <= 11))
		else $error("accepted seed outside popcount window");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

endmodule

bind lcg_mixed_seed_generator lcgmx_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
